FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off during reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked from the edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rat_alu_pkg.sv
// ----------------------------------------------------------------------------
// rat_alu_pkg
// Types and constants of the rational accumulator ALU.
// ----------------------------------------------------------------------------
package rat_alu_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int ACC_WIDTH     = 32;
    // operand after moving the sign off the denominator (-min fits)
    localparam int OPN_W  = OPERAND_WIDTH + 1;
    // cross products and their sum
    localparam int PROD_W = ACC_WIDTH + 1 + OPN_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int CNT_W  = $clog2(MAG_W);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_SUB  = 2'd2;
    localparam logic [1:0] CMD_LESS = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]                        command;
        logic signed [OPERAND_WIDTH-1:0]   operand_num;
        logic signed [OPERAND_WIDTH-1:0]   operand_den;
    } t_req;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0]       acc_num_out;
        logic [ACC_WIDTH-2:0]              acc_den_out;
        logic                              is_less;
        logic [1:0]                        status;
    } t_rsp;

endpackage

FILE: src/rational_accumulator_alu_top.sv
// ----------------------------------------------------------------------------
// rational_accumulator_alu_top
// Reduced-fraction accumulator: load, add, subtract, compare-less.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                        payload
//  request   in   i_req_valid / o_req_ready        i_req (t_req)
//  response  out  o_rsp_valid / i_rsp_ready        o_rsp (t_rsp)
//
//  One request at a time; one shared 33x17 multiplier, a subtract/compare
//  datapath for the binary GCD and a bit-serial divider set the latency.
//  Load: binary GCD, division of numerator and denominator, overflow check;
//  add/sub: cross products and sum first; compare: cross products only;
//  zero denominator: straight to the response. Ready again the cycle after
//  the response loads. A finished response waits in the output register; the
//  next request is taken meanwhile. Synchronous active-low reset: acc = 0/1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_accumulator_alu_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  rat_alu_pkg::t_req    i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output rat_alu_pkg::t_rsp    o_rsp
);

    localparam int ACCW  = rat_alu_pkg::ACC_WIDTH;
    localparam int OPNW  = rat_alu_pkg::OPN_W;
    localparam int PRODW = rat_alu_pkg::PROD_W;
    localparam int MAGW  = rat_alu_pkg::MAG_W;
    localparam int CNTW  = rat_alu_pkg::CNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_PREP = 4'd6;
    localparam logic [3:0] S_GCD  = 4'd7;
    localparam logic [3:0] S_DIVN = 4'd8;
    localparam logic [3:0] S_DIVD = 4'd9;
    localparam logic [3:0] S_CHK  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam logic [MAGW-1:0] LIM     = MAGW'(1) << (ACCW - 1);
    localparam logic [MAGW-1:0] LIM_M1  = LIM - MAGW'(1);
    localparam logic [CNTW-1:0] CNT_END = CNTW'(MAGW - 1);

    logic [3:0]              r_state;
    logic [1:0]              r_cmd;
    logic signed [OPNW-1:0]  r_on, r_od;
    logic signed [ACCW-1:0]  r_acc_num;
    logic [ACCW-1:0]         r_acc_den;
    logic signed [PRODW-1:0] r_t1, r_t2, r_num;
    logic [MAGW-1:0]         r_den;
    logic                    r_neg, r_less;
    logic [1:0]              r_status;
    logic [MAGW-1:0]         r_nm, r_dm, r_a, r_b, r_q, r_rem;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_rsp_valid;
    rat_alu_pkg::t_rsp       r_rsp;

    // shared multiplier
    logic signed [ACCW:0]        mul_a;
    logic signed [OPNW-1:0]      mul_b;
    logic signed [ACCW+OPNW:0]   mul_p;
    logic signed [PRODW-1:0]     mul_res;

    always_comb begin
        case (r_state)
            S_MUL2:  begin mul_a = $signed({1'b0, r_acc_den}); mul_b = r_on; end
            S_MUL3:  begin mul_a = $signed({1'b0, r_acc_den}); mul_b = r_od; end
            default: begin mul_a = {r_acc_num[ACCW-1], r_acc_num}; mul_b = r_od; end
        endcase
        mul_p   = mul_a * mul_b;
        mul_res = mul_p[PRODW-1:0];
    end

    // input sign normalization
    logic signed [OPNW-1:0] in_on, in_od;
    always_comb begin
        in_on = {i_req.operand_num[OPNW-2], i_req.operand_num};
        in_od = {i_req.operand_den[OPNW-2], i_req.operand_den};
        if (in_od < 0) begin
            in_on = -in_on;
            in_od = -in_od;
        end
    end

    // bit-serial restoring divider step
    logic [MAGW:0]   div_sh, div_diff;
    logic            div_bit;
    logic [MAGW-1:0] div_q, div_rem;
    always_comb begin
        div_sh   = {r_rem, r_q[MAGW-1]};
        div_diff = div_sh - {1'b0, r_a};
        div_bit  = !div_diff[MAGW];
        div_rem  = div_bit ? div_diff[MAGW-1:0] : div_sh[MAGW-1:0];
        div_q    = {r_q[MAGW-2:0], div_bit};
    end

    logic [PRODW-1:0] num_abs;
    assign num_abs = r_num[PRODW-1] ? PRODW'(-r_num) : PRODW'(r_num);

    logic ovf;
    assign ovf = (r_dm > LIM_M1) || (r_neg ? (r_nm > LIM) : (r_nm > LIM_M1));

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_acc_num   <= '0;
            r_acc_den   <= ACCW'(1);
        end else begin
            // S_DONE reloads the output itself
            if (r_rsp_valid && i_rsp_ready && (r_state != S_DONE)) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd    <= i_req.command;
                        r_on     <= in_on;
                        r_od     <= in_od;
                        r_less   <= 1'b0;
                        r_status <= (i_req.operand_den == '0) ? rat_alu_pkg::ST_ZERO_DEN
                                                              : rat_alu_pkg::ST_OK;
                        r_num    <= PRODW'(in_on);
                        r_den    <= MAGW'(in_od);
                        if (i_req.operand_den == '0) begin
                            r_state  <= S_DONE;
                        end else if (i_req.command == rat_alu_pkg::CMD_LOAD) begin
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_t1    <= mul_res;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_t2    <= mul_res;
                    r_state <= (r_cmd == rat_alu_pkg::CMD_LESS) ? S_CMP : S_MUL3;
                end
                S_MUL3: begin
                    r_den   <= MAGW'(mul_res);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num   <= (r_cmd == rat_alu_pkg::CMD_SUB) ? r_t1 - r_t2 : r_t1 + r_t2;
                    r_state <= S_PREP;
                end
                S_CMP: begin
                    r_less  <= (r_t1 < r_t2);
                    r_state <= S_DONE;
                end
                S_PREP: begin
                    r_neg <= r_num[PRODW-1];
                    r_nm  <= num_abs[MAGW-1:0];
                    r_dm  <= r_den;
                    r_a   <= num_abs[MAGW-1:0];
                    r_b   <= r_den;
                    if (r_num == '0) begin
                        r_acc_num <= '0;
                        r_acc_den <= ACCW'(1);
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // common factors of two come first, so nm/dm track a/b then
                    if (r_a == r_b) begin
                        r_q     <= r_nm;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a  <= r_a >> 1;
                        r_b  <= r_b >> 1;
                        r_nm <= r_nm >> 1;
                        r_dm <= r_dm >> 1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a > r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                S_DIVN: begin
                    if (r_cnt == CNT_END) begin
                        r_nm    <= div_q;
                        r_q     <= r_dm;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVD;
                    end else begin
                        r_q   <= div_q;
                        r_rem <= div_rem;
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                S_DIVD: begin
                    r_q   <= div_q;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNT_END) begin
                        r_dm    <= div_q;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (ovf) begin
                        r_status <= rat_alu_pkg::ST_OVERFLOW;
                    end else begin
                        r_acc_num <= r_neg ? -ACCW'(r_nm) : ACCW'(r_nm);
                        r_acc_den <= ACCW'(r_dm);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_rsp_valid || i_rsp_ready) begin
                        r_rsp.acc_num_out <= r_acc_num;
                        r_rsp.acc_den_out <= r_acc_den[ACCW-2:0];
                        r_rsp.is_less     <= r_less;
                        r_rsp.status      <= r_status;
                        r_rsp_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLKD(a_den_nonzero, i_clk, i_rst_n, (r_acc_den != '0),
                 "accumulator denominator is zero")
    `ASSERT_CLKD(a_gcd_nonzero, i_clk, i_rst_n,
                 ((r_state == S_GCD) |-> (r_a != '0 && r_b != '0)),
                 "GCD operand reached zero")
    `ASSERT_NEXT(a_acc_hold, i_clk, i_rst_n,
                 (r_state == S_GCD || r_state == S_DIVN || r_state == S_CMP),
                 ($stable(r_acc_num) && $stable(r_acc_den)),
                 "accumulator changed mid-operation")

endmodule
